@@ design/rbsi_pkg.sv @@
// Shared types and constants for the ray and box slab intersection block.
// Holds the divider and pipeline record types; depends on nothing else.
package rbsi_pkg;

  localparam int FracBitsDefault = 16;
  localparam int NumDiv = 6;
  localparam int DivSteps = 32;
  localparam int NumRegs = 6;
  localparam int AddrWidth = 5;

  localparam logic [2:0] RegMinX = 3'd0;
  localparam logic [2:0] RegMinY = 3'd1;
  localparam logic [2:0] RegMinZ = 3'd2;
  localparam logic [2:0] RegMaxX = 3'd3;
  localparam logic [2:0] RegMaxY = 3'd4;
  localparam logic [2:0] RegMaxZ = 3'd5;

  localparam logic signed [31:0] TMax = 32'sh7fff_ffff;
  localparam logic signed [31:0] TMin = 32'sh8000_0000;

  typedef struct packed {
    logic [31:0] r;
    logic [31:0] q;
    logic [31:0] d;
    logic        neg;
    logic        ovf;
  } div_t;

  typedef struct packed {
    logic [2:0]         zero;
    logic [2:0]         in_slab;
    logic signed [31:0] t_start;
    logic signed [31:0] t_end;
  } side_t;

  function automatic div_t div_step(div_t x);
    logic [32:0] t;
    logic [32:0] df;
    div_t        y;
    t  = {x.r, x.q[31]};
    df = t - {1'b0, x.d};
    y  = x;
    if (!df[32]) begin
      y.r = df[31:0];
      y.q = {x.q[30:0], 1'b1};
    end else begin
      y.r = t[31:0];
      y.q = {x.q[30:0], 1'b0};
    end
    return y;
  endfunction

  function automatic logic signed [31:0] div_result(div_t x);
    logic signed [31:0] res;
    if (!x.neg) begin
      if (x.ovf || x.q[31]) res = TMax;
      else res = x.q;
    end else begin
      if (x.ovf || (x.q > 32'h8000_0000)) res = TMin;
      else res = -x.q;
    end
    return res;
  endfunction

endpackage

@@ design/ray_box_slab_intersect.sv @@
// Top level of the ray and box slab intersection block: APB box registers,
// a 32-step pipelined divider per slab plane and the min/max reduction.
// Depends on rbsi_pkg.
//
//   channel  | ports                                        | transfer when
//   ---------+----------------------------------------------+-------------------------
//   rays in  | in_valid, in_ready, origin_*, dir_*, interval_*| in_valid && in_ready
//   result   | out_valid, out_ready, hit, entry_distance    | out_valid && out_ready
//   config   | psel, penable, pwrite, paddr, pwdata, prdata | psel && penable && pwrite
//
// One ray is taken every cycle unless the result is held by out_ready low.
// Rays pass the six 32-stage restoring dividers, one quotient bit per stage.
// Reset clears all valid bits and the box registers to zero.
// When the result is held by out_ready low, the whole pipeline freezes and in_ready drops.
module ray_box_slab_intersect #(
  parameter int FRAC_BITS = rbsi_pkg::FracBitsDefault
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rbsi_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [31:0]             origin_x,
  input  logic signed [31:0]             origin_y,
  input  logic signed [31:0]             origin_z,
  input  logic signed [31:0]             dir_x,
  input  logic signed [31:0]             dir_y,
  input  logic signed [31:0]             dir_z,
  input  logic signed [31:0]             interval_start,
  input  logic signed [31:0]             interval_end,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           hit,
  output logic signed [31:0]             entry_distance
);
  import rbsi_pkg::*;

  localparam int NumW = 33 + FRAC_BITS;
  localparam int HiW = NumW - 32;

  logic signed [31:0] box_lo [0:2];
  logic signed [31:0] box_hi [0:2];
  logic [2:0]         reg_idx;
  logic               en;

  div_t  dv   [0:DivSteps][0:NumDiv-1];
  side_t sd   [0:DivSteps];
  logic  vld  [0:DivSteps];
  div_t  dv_in [0:NumDiv-1];
  side_t sd_in;

  logic               va;
  logic signed [31:0] en_a [0:2];
  logic signed [31:0] lv_a [0:2];
  logic               ok_a;
  logic signed [31:0] ts_a;
  logic signed [31:0] te_a;

  logic               vb;
  logic signed [31:0] near_b;
  logic signed [31:0] far_b;
  logic               ok_b;

  assign pready = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        box_lo[i] <= '0;
        box_hi[i] <= '0;
      end
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        RegMinX: box_lo[0] <= pwdata;
        RegMinY: box_lo[1] <= pwdata;
        RegMinZ: box_lo[2] <= pwdata;
        RegMaxX: box_hi[0] <= pwdata;
        RegMaxY: box_hi[1] <= pwdata;
        RegMaxZ: box_hi[2] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegMinX: prdata = box_lo[0];
      RegMinY: prdata = box_lo[1];
      RegMinZ: prdata = box_lo[2];
      RegMaxX: prdata = box_hi[0];
      RegMaxY: prdata = box_hi[1];
      RegMaxZ: prdata = box_hi[2];
      default: prdata = '0;
    endcase
  end

  assign en = !out_valid || out_ready;
  assign in_ready = en;

  always_comb begin
    logic signed [31:0] org [0:2];
    logic signed [31:0] dir [0:2];
    logic signed [32:0] diff;
    logic [32:0]        mag;
    logic [NumW-1:0]    num;
    logic [31:0]        dmag;
    logic signed [31:0] c;
    logic signed [31:0] a;
    logic signed [31:0] b;
    org[0] = origin_x; org[1] = origin_y; org[2] = origin_z;
    dir[0] = dir_x;    dir[1] = dir_y;    dir[2] = dir_z;
    sd_in.t_start = interval_start;
    sd_in.t_end   = interval_end;
    for (int ax = 0; ax < 3; ax++) begin
      a = (box_lo[ax] < box_hi[ax]) ? box_lo[ax] : box_hi[ax];
      b = (box_lo[ax] < box_hi[ax]) ? box_hi[ax] : box_lo[ax];
      sd_in.zero[ax]    = (dir[ax] == 32'sd0);
      sd_in.in_slab[ax] = (org[ax] >= a) && (org[ax] <= b);
      dmag = dir[ax][31] ? (32'd0 - dir[ax]) : dir[ax];
      for (int k = 0; k < 2; k++) begin
        c    = (k == 0) ? box_lo[ax] : box_hi[ax];
        diff = {c[31], c} - {org[ax][31], org[ax]};
        mag  = diff[32] ? (33'd0 - diff) : diff;
        num  = {{(NumW-33){1'b0}}, mag} << FRAC_BITS;
        dv_in[2*ax+k].d   = dmag;
        dv_in[2*ax+k].r   = {{(32-HiW){1'b0}}, num[NumW-1:32]};
        dv_in[2*ax+k].q   = num[31:0];
        dv_in[2*ax+k].ovf = ({{(32-HiW){1'b0}}, num[NumW-1:32]} >= dmag);
        dv_in[2*ax+k].neg = diff[32] ^ dir[ax][31];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else if (en) vld[0] <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= sd_in;
      for (int k = 0; k < NumDiv; k++) dv[0][k] <= dv_in[k];
    end
  end

  for (genvar s = 1; s <= DivSteps; s++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) vld[s] <= 1'b0;
      else if (en) vld[s] <= vld[s-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sd[s] <= sd[s-1];
        for (int k = 0; k < NumDiv; k++) dv[s][k] <= div_step(dv[s-1][k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else if (en) va <= vld[DivSteps];
  end

  always_ff @(posedge clk) begin
    logic signed [31:0] t0;
    logic signed [31:0] t1;
    if (en) begin
      for (int ax = 0; ax < 3; ax++) begin
        t0 = div_result(dv[DivSteps][2*ax]);
        t1 = div_result(dv[DivSteps][2*ax+1]);
        if (sd[DivSteps].zero[ax]) begin
          en_a[ax] <= TMin;
          lv_a[ax] <= TMax;
        end else begin
          en_a[ax] <= (t0 < t1) ? t0 : t1;
          lv_a[ax] <= (t0 < t1) ? t1 : t0;
        end
      end
      ok_a <= &(~sd[DivSteps].zero | sd[DivSteps].in_slab);
      ts_a <= sd[DivSteps].t_start;
      te_a <= sd[DivSteps].t_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vb <= 1'b0;
    else if (en) vb <= va;
  end

  always_ff @(posedge clk) begin
    logic signed [31:0] n;
    logic signed [31:0] f;
    if (en) begin
      n = ts_a;
      f = te_a;
      for (int ax = 0; ax < 3; ax++) begin
        if (en_a[ax] > n) n = en_a[ax];
        if (lv_a[ax] < f) f = lv_a[ax];
      end
      near_b <= n;
      far_b  <= f;
      ok_b   <= ok_a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= vb;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (ok_b && (near_b <= far_b)) begin
        hit            <= 1'b1;
        entry_distance <= near_b;
      end else begin
        hit            <= 1'b0;
        entry_distance <= '0;
      end
    end
  end

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> entry_distance == 32'sd0)
    else $error("miss result carries a nonzero distance");

  a_div_to_a: assert property (@(posedge clk) disable iff (rst)
    en && vld[DivSteps] |=> va)
    else $error("divider output lost on its way to the ordering stage");

  a_slab_miss: assert property (@(posedge clk) disable iff (rst)
    en && vb && !ok_b |=> out_valid && !hit)
    else $error("ray outside a flat slab reported as a hit");

  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(vb) && $stable(near_b))
    else $error("pipeline moved while the result was held");

endmodule

@@ tb/tb_ray_box_slab_intersect.sv @@
// Testbench for ray_box_slab_intersect: drives rays and box registers, predicts
// each slab-test result in place and checks every result transfer in order.
// Depends on rbsi_pkg and the ray_box_slab_intersect RTL.
module tb_ray_box_slab_intersect;
  timeunit 1ns;
  timeprecision 1ps;
  import rbsi_pkg::*;

  typedef struct packed {
    logic signed [31:0] ox, oy, oz, dx, dy, dz, ts, te;
  } ray_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] distance;
  } isect_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [AddrWidth-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  ray_t ray_q = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic hit;
  logic signed [31:0] entry_distance;

  logic signed [31:0] box_lo [3];
  logic signed [31:0] box_hi [3];
  isect_t expected_q [$];
  int mismatches = 0;
  int results_seen = 0;
  int hold_cycles = 0;
  int stall_mode = 0;
  longint cycle_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ray_box_slab_intersect u_top (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_ready,
    .origin_x(ray_q.ox), .origin_y(ray_q.oy), .origin_z(ray_q.oz),
    .dir_x(ray_q.dx), .dir_y(ray_q.dy), .dir_z(ray_q.dz),
    .interval_start(ray_q.ts), .interval_end(ray_q.te),
    .out_valid, .out_ready, .hit, .entry_distance
  );

  function automatic logic signed [31:0] plane_param(logic signed [31:0] corner,
                                                     logic signed [31:0] org,
                                                     logic signed [31:0] dir);
    longint num;
    longint q;
    num = (longint'(corner) - longint'(org)) * (64'sd1 <<< FracBitsDefault);
    q = num / longint'(dir);
    if (q > longint'(TMax)) return TMax;
    if (q < longint'(TMin)) return TMin;
    return q[31:0];
  endfunction

  function automatic isect_t predict_isect(ray_t r);
    logic signed [31:0] o [3];
    logic signed [31:0] d [3];
    logic signed [31:0] near_t, far_t, t0, t1, en, lv, a, b;
    logic ok;
    isect_t res;
    o[0] = r.ox; o[1] = r.oy; o[2] = r.oz;
    d[0] = r.dx; d[1] = r.dy; d[2] = r.dz;
    near_t = r.ts;
    far_t = r.te;
    ok = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (d[i] == 0) begin
        a = (box_lo[i] < box_hi[i]) ? box_lo[i] : box_hi[i];
        b = (box_lo[i] < box_hi[i]) ? box_hi[i] : box_lo[i];
        en = TMin;
        lv = TMax;
        if (!(o[i] >= a && o[i] <= b)) ok = 1'b0;
      end else begin
        t0 = plane_param(box_lo[i], o[i], d[i]);
        t1 = plane_param(box_hi[i], o[i], d[i]);
        en = (t0 < t1) ? t0 : t1;
        lv = (t0 < t1) ? t1 : t0;
      end
      if (en > near_t) near_t = en;
      if (lv < far_t) far_t = lv;
    end
    if (ok && near_t <= far_t) begin
      res.hit = 1'b1;
      res.distance = near_t;
    end else begin
      res = '0;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("[ray_box_slab_intersect] ERROR");
      $finish;
    end
  end

  // Receiver stall pattern; a long hold-off overrides it.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    isect_t exp_r;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer: hit=%0b dist=%0d",
                                       hit, entry_distance);
      end else begin
        exp_r = expected_q.pop_front();
        if (hit !== exp_r.hit || entry_distance !== exp_r.distance) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected hit=%0b dist=%0d, got hit=%0b dist=%0d",
                     exp_r.hit, exp_r.distance, hit, entry_distance);
        end
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic signed [31:0] val);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= AddrWidth'(idx) << 2; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx < 3) box_lo[idx] = val;
    else box_hi[idx - 3] = val;
  endtask

  task automatic set_box(logic signed [31:0] lx, ly, lz, hx, hy, hz);
    write_reg(RegMinX, lx); write_reg(RegMinY, ly); write_reg(RegMinZ, lz);
    write_reg(RegMaxX, hx); write_reg(RegMaxY, hy); write_reg(RegMaxZ, hz);
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic send_ray(ray_t r);
    in_valid <= 1'b1;
    ray_q <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_q.push_back(predict_isect(r));
  endtask

  task automatic idle_cycles(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return TMin + $urandom_range(0, 3);
      2: return TMax - $urandom_range(0, 3);
      default: return $signed($urandom_range(0, 32'h0014_0000)) - 32'sh000a_0000;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_dir();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return $urandom();
      2: return $signed($urandom_range(0, 4)) - 2;
      3: return ($urandom_range(0, 1)) ? TMin : TMax;
      default: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
    endcase
  endfunction

  function automatic ray_t rand_ray();
    ray_t r;
    r.ox = rand_coord(); r.oy = rand_coord(); r.oz = rand_coord();
    r.dx = rand_dir(); r.dy = rand_dir(); r.dz = rand_dir();
    case ($urandom_range(0, 4))
      0: begin r.ts = $urandom(); r.te = $urandom(); end
      1: begin r.ts = TMin; r.te = TMax; end
      default: begin
        r.ts = $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0001_0000;
        r.te = r.ts + $signed($urandom_range(0, 32'h0100_0000));
      end
    endcase
    return r;
  endfunction

  task automatic test_directed();
    ray_t r;
    set_box(-32'sh0001_0000, -32'sh0001_0000, -32'sh0001_0000,
            32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000);
    r = '{-32'sh0005_0000, 0, 0, 32'sh0001_0000, 0, 0, 0, 32'sh0010_0000};
    send_ray(r);
    r.oy = 32'sh0002_0000; send_ray(r);
    r.oy = 32'sh0001_0000; send_ray(r);
    r = '{0, 0, 0, 0, 0, 0, TMin, TMax}; send_ray(r);
    r.ts = 5; r.te = 4; send_ray(r);
    r = '{TMax, TMin, TMax, 1, -1, TMin, TMin, TMax}; send_ray(r);
    r = '{TMin, TMax, TMin, TMax, TMin, 1, TMin, TMax}; send_ray(r);
    r = '{-32'sh0005_0000, 0, 0, -32'sh0001_0000, 1, -1, TMin, TMax}; send_ray(r);
    r = '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
          32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff};
    send_ray(r);
    idle_cycles(1);
    drain();
    // Inverted box on every axis, then extreme corners.
    set_box(32'sh0003_0000, 32'sh0003_0000, 32'sh0003_0000, 0, 0, 0);
    r = '{32'sh0001_0000, 32'sh0001_0000, -32'sh0001_0000, 0, 0, 32'sh0000_8000,
          0, TMax};
    send_ray(r);
    r.dz = 0; send_ray(r);
    idle_cycles(1);
    drain();
    set_box(TMin, TMin, TMin, TMax, TMax, TMax);
    r = '{0, 0, 0, 1, 1, 1, TMin, TMax}; send_ray(r);
    r = '{TMin, TMax, 0, 32'sh0000_0100, -32'sh0000_0100, 0, 0, TMax}; send_ray(r);
    idle_cycles(1);
    drain();
  endtask

  task automatic test_random(int n);
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 30);
      for (int k = 0; k < burst && n > 0; k++, n--) send_ray(rand_ray());
      if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 8));
    end
    idle_cycles(1);
    drain();
  endtask

  task automatic test_backpressure();
    hold_cycles = 200;
    for (int k = 0; k < 80; k++) send_ray(rand_ray());
    idle_cycles(1);
    drain();
  endtask

  initial begin
    ray_t r;
    box_lo = '{0, 0, 0};
    box_hi = '{0, 0, 0};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    for (int ph = 0; ph < 6; ph++) begin
      stall_mode = ph % 3;
      set_box(rand_coord(), rand_coord(), rand_coord(),
              rand_coord(), rand_coord(), rand_coord());
      if (ph == 0) set_box(-32'sh0004_0000, -32'sh0004_0000, -32'sh0004_0000,
                           32'sh0004_0000, 32'sh0004_0000, 32'sh0004_0000);
      test_random(220);
    end
    stall_mode = 1;
    test_backpressure();
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("[ray_box_slab_intersect] OK");
    end else begin
      $display("[ray_box_slab_intersect] ERROR");
    end
    $finish;
  end
endmodule
